// ===== rtl/utt_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; imported by the front, queue and back modules.
package utt_pkg;

    // Upper six bits of a surrogate code unit.
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // First code point of the supplementary planes.
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Queue depth between front and back.
    localparam int unsigned JOB_DEPTH = 2;

    // One classified job: an optional held surrogate to flush as three bytes,
    // then an optional code point to encode.
    typedef struct packed {
        logic        pre_valid;
        logic [9:0]  pre_bits;
        logic        main_valid;
        logic [20:0] main_cp;
        logic        last;
    } utt_job_t;

endpackage

// ===== rtl/utt_front.sv =====
// Front end: accepts UTF-16 code units, pairs surrogates and emits code point jobs.
// Depends on utt_pkg.
module utt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       code_unit,
    input  logic              last_unit,
    input  logic              job_full,
    output logic              job_push,
    output utt_pkg::utt_job_t job
);
    import utt_pkg::*;

    logic       pending_valid_reg;
    logic       pending_valid_next;
    logic [9:0] pending_bits_reg;
    logic [9:0] pending_bits_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       pair_done;

    assign in_stall  = job_full;
    assign accept    = in_valid && !job_full;
    assign is_high   = (code_unit[15:10] == HIGH_SURR_TAG);
    assign is_low    = (code_unit[15:10] == LOW_SURR_TAG);
    assign pair_done = pending_valid_reg && is_low;

    always_comb
    begin
        job            = '0;
        job.last       = last_unit;
        if (pending_valid_reg)
        begin
            if (is_low)
            begin
                job.main_valid = 1'b1;
                job.main_cp    = SUPP_BASE + {1'b0, pending_bits_reg, code_unit[9:0]};
            end
            else
            begin
                job.pre_valid = 1'b1;
                job.pre_bits  = pending_bits_reg;
            end
        end
        if (!pair_done && !(is_high && !last_unit))
        begin
            job.main_valid = 1'b1;
            job.main_cp    = {5'b0, code_unit};
        end
    end

    assign job_push = accept && (job.pre_valid || job.main_valid);

    always_comb
    begin
        pending_valid_next = pending_valid_reg;
        pending_bits_next  = pending_bits_reg;
        if (accept)
        begin
            // A high surrogate that is not the last unit waits for its partner.
            pending_valid_next = !pair_done && is_high && !last_unit;
            pending_bits_next  = pending_valid_next ? code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_bits_reg  <= 10'd0;
        end
        else
        begin
            pending_valid_reg <= pending_valid_next;
            pending_bits_reg  <= pending_bits_next;
        end
    end

endmodule

// ===== rtl/utt_fifo.sv =====
// Short job queue between the front and back ends.
// Depends on utt_pkg.
module utt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utt_pkg::utt_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              job_valid,
    output utt_pkg::utt_job_t job
);
    import utt_pkg::*;

    localparam int unsigned PTR_W = $clog2(JOB_DEPTH);
    localparam int unsigned CNT_W = $clog2(JOB_DEPTH + 1);

    utt_job_t         mem [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(JOB_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/utt_back.sv =====
// Back end: encodes a queued job into UTF-8 bytes and sends them one per beat.
// Depends on utt_pkg.
module utt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  utt_pkg::utt_job_t job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              run_last,
    output logic              end_of_text
);
    import utt_pkg::*;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } enc_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        if (cp < 21'h80)
        begin
            e.bytes = {cp[7:0], 24'h0};
            e.len   = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            e.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            e.len   = 3'd2;
        end
        else if (cp < SUPP_BASE)
        begin
            e.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            e.len   = 3'd3;
        end
        else
        begin
            e.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
            e.len   = 3'd4;
        end
        return e;
    endfunction

    logic [47:0] bytes_reg;
    logic [47:0] bytes_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        last_reg;
    logic        last_next;
    logic        out_accept;
    logic        final_beat;
    enc_t        main_enc;
    logic [47:0] load_bytes;
    logic [2:0]  load_cnt;

    assign out_valid   = busy_reg;
    assign out_accept  = busy_reg && !out_stall;
    assign final_beat  = (cnt_reg == 3'd1);
    assign out_byte    = bytes_reg[47:40];
    assign run_last    = final_beat;
    assign end_of_text = final_beat && last_reg;
    assign job_pop     = job_valid && (!busy_reg || (out_accept && final_beat));

    always_comb
    begin
        main_enc = encode_cp(job.main_cp);
        if (job.pre_valid)
        begin
            // A flushed high surrogate always encodes as ED, 10xx_bbbb, 10bb_bbbb.
            // The unit after it lies in the BMP, so at most three bytes follow.
            load_bytes = {8'hED, 4'b1010, job.pre_bits[9:6], 2'b10, job.pre_bits[5:0],
                          main_enc.bytes[31:8]};
            load_cnt   = job.main_valid ? 3'd3 + main_enc.len : 3'd3;
        end
        else
        begin
            load_bytes = {main_enc.bytes, 16'h0};
            load_cnt   = main_enc.len;
        end
    end

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        last_next  = last_reg;
        if (job_pop)
        begin
            bytes_next = load_bytes;
            cnt_next   = load_cnt;
            busy_next  = 1'b1;
            last_next  = job.last;
        end
        else if (out_accept)
        begin
            bytes_next = {bytes_reg[39:0], 8'h0};
            cnt_next   = cnt_reg - 1'b1;
            busy_next  = !final_beat;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder top level. The first byte of a unit is offered once its
// job is written into the queue and then loaded into the back end's byte register.
// Output: one byte per cycle while out_stall is low. A unit yields 0 to 6 bytes; the
// back end's byte serializer loads the next job as the last byte of a job is taken.
// A two-entry job queue lets input keep flowing while bytes drain. Reset clears the
// held surrogate and queue.
module utf16_to_utf8_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        end_of_text
);
    import utt_pkg::*;

    utt_job_t push_job;
    utt_job_t head_job;
    logic     job_push;
    logic     job_full;
    logic     job_valid;
    logic     job_pop;

    utt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .job_full  (job_full),
        .job_push  (job_push),
        .job       (push_job)
    );

    utt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (job_full),
        .pop       (job_pop),
        .job_valid (job_valid),
        .job       (head_job)
    );

    utt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .end_of_text (end_of_text)
    );

endmodule
